// ----- design/mrw_pkg.sv -----
// Package for the multifractal random walk step core: constants, codes and ROM functions.
`default_nettype none
package mrw_pkg;

    localparam int NC_DEF  = 64;   // default history depth
    localparam int PHI_W   = 24;   // phi accumulator width, Q1.17 sums stay well inside
    localparam int ROOT_N  = 16;   // fraction bits of the exponent, one root each
    localparam int CFG_W   = 24;   // config data width
    localparam int CFG_IW  = 3;    // config index width

    typedef enum logic [CFG_IW-1:0] {
        CFG_GAIN_A      = 3'd0,
        CFG_DRIFT       = 3'd1,
        CFG_START_LEVEL = 3'd2,
        CFG_MAX_LEVEL   = 3'd3,
        CFG_BASE_SCALE  = 3'd4,
        CFG_LOG2_LAMBDA = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHI,
        ST_MUL,
        ST_LEVEL,
        ST_EXP,
        ST_POW,
        ST_SCALE,
        ST_SMUL,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // bitwise integer square root, elaboration time only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = v;
        for (int n = 0; n < 32; n++)
        begin
            if (b != 64'd0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q2.30 root 2^(2^-(k+1))
    function automatic logic [63:0] exp_root(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int n = 0; n < k; n++)
        begin
            c = isqrt64(c << 30);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/mrw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrw_ram #(
    parameter int W = 1,
    parameter int D = 65
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/multifractal_random_walk_step_core.sv -----
// Top level of the multifractal random walk step core.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall   | start_of_path, eta_sign, gauss_sample
//  out     | output    | out_valid/out_stall | path_value, step_value, level
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One item at a time. The phi pass walks the sign history in RAM, one tap per
// cycle, with no read while the history is empty. Then one gain multiply, level
// update, exponent, 16 root multiplies for 2^frac, scale and sample multiplies,
// shift and accumulate. The next beat is accepted only once this one has taken
// the output register, which waits while out_stall holds a full output.
// Reset clears time count, level and path sum, config to defaults; the history
// RAM is never cleared, entries not yet written since the path start are unused.
// in_stall is high while an item is at work; a finished beat waits in the output
// register while out_stall holds, and the next beat is accepted meanwhile.
`default_nettype none
module multifractal_random_walk_step_core #(
    parameter int NC = mrw_pkg::NC_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        start_of_path,
    input  wire logic                        eta_sign,
    input  wire logic signed [15:0]          gauss_sample,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [47:0]               path_value,
    output logic signed [31:0]               step_value,
    output logic        [23:0]               level,
    input  wire logic                        cfg_we,
    input  wire logic [mrw_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [mrw_pkg::CFG_W-1:0]   cfg_data
);

    localparam int D  = NC + 1;            // history entries
    localparam int KW = $clog2(NC + 1);    // history address / tap index width
    localparam int TW = $clog2(NC + 2);    // time count width, holds NC+1
    localparam int PW = mrw_pkg::PHI_W;
    localparam int LW = 50;                // level sum width

    // ---------------- constant tables ----------------
    logic [17:0] ktab  [D];                // K_i = 1/sqrt(i+1), Q1.17
    logic [31:0] roots [mrw_pkg::ROOT_N];  // 2^(2^-(k+1)), Q2.30

    for (genvar g = 0; g < D; g++)
    begin : g_ktab
        localparam logic [63:0] Q = (64'd1 << 36) / (g + 1);
        assign ktab[g] = 18'((mrw_pkg::isqrt64(Q) + 64'd1) >> 1);
    end

    for (genvar g = 0; g < mrw_pkg::ROOT_N; g++)
    begin : g_roots
        assign roots[g] = 32'(mrw_pkg::exp_root(g));
    end

    // ---------------- registers ----------------
    mrw_pkg::state_t state_reg, state_next;

    logic signed [23:0] gain_reg, drift_reg;
    logic        [23:0] start_reg, max_reg, base_reg;
    logic        [19:0] log2_reg;

    logic [TW-1:0]      tcnt_reg;          // signs stored since path start, sat NC+1
    logic [KW-1:0]      ptr_reg;           // next write slot, also the oldest sign
    logic [23:0]        level_reg;
    logic signed [47:0] path_reg;

    logic               pos_reg;
    logic [15:0]        gs_reg;
    logic [TW-1:0]      a_reg;             // next tap to read, 0-based
    logic               p_vld_reg;         // read in flight
    logic [KW-1:0]      p_idx_reg;
    logic signed [PW-1:0] phi_reg;
    logic signed [47:0] prod_reg;
    logic [11:0]        ei_reg;
    logic [15:0]        f_reg;
    logic [3:0]         k_reg;
    logic [30:0]        mant_reg;
    logic [24:0]        bm_reg;
    logic [41:0]        m2_reg;
    logic signed [31:0] step_reg;

    logic               out_valid_reg;
    logic signed [47:0] out_path_reg;
    logic signed [31:0] out_step_reg;
    logic [23:0]        out_level_reg;

    // ---------------- history RAM ----------------
    logic          issue;
    logic [KW-1:0] raddr;
    logic [KW:0]   raddr_w;
    logic          rd_sign;
    logic          hist_we;

    assign issue   = (state_reg == mrw_pkg::ST_PHI) && (a_reg < tcnt_reg);
    assign hist_we = (state_reg == mrw_pkg::ST_MUL);

    // tap j = a+1 sits j slots behind the write pointer
    always_comb
    begin
        if ({1'b0, ptr_reg} > (KW+1)'(a_reg))
        begin
            raddr_w = {1'b0, ptr_reg} - (KW+1)'(a_reg) - (KW+1)'(1);
        end
        else
        begin
            raddr_w = {1'b0, ptr_reg} + (KW+1)'(NC) - (KW+1)'(a_reg);
        end
        raddr = raddr_w[KW-1:0];
    end

    mrw_ram #(
        .W (1),
        .D (D)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (pos_reg),
        .raddr (raddr),
        .rdata (rd_sign)
    );

    // ---------------- datapath combinational ----------------
    logic               in_acc;
    logic               out_load;
    logic [17:0]        k_prev, k_next;
    logic signed [18:0] coef;
    logic signed [LW-1:0] lvl_sum;
    logic [23:0]        lvl_clamp;
    logic [43:0]        e_full;
    logic [61:0]        mprod;
    logic [54:0]        bprod;
    logic [16:0]        smag;
    logic [31:0]        limit;
    logic [11:0]        sh;
    logic [3:0]         sh_r;
    logic [41:0]        mag;
    logic signed [48:0] psum;
    logic signed [47:0] path_sat;

    assign in_acc   = in_valid && !in_stall;
    assign out_load = (state_reg == mrw_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        // tap coefficient K_j - K_(j-1); the oldest sign gets -K_NC
        k_prev = ktab[p_idx_reg];
        k_next = (p_idx_reg == KW'(NC)) ? 18'd0 : ktab[KW'(p_idx_reg + KW'(1))];
        coef   = $signed({1'b0, k_next}) - $signed({1'b0, k_prev});

        lvl_sum = LW'($signed({1'b0, level_reg}))
                + (pos_reg ? LW'(65536) : -LW'(65536))
                + LW'(prod_reg >>> 17)
                - LW'(drift_reg);
        if (lvl_sum < 0)
        begin
            lvl_clamp = '0;
        end
        else if (lvl_sum > LW'($signed({1'b0, max_reg})))
        begin
            lvl_clamp = max_reg;
        end
        else
        begin
            lvl_clamp = lvl_sum[23:0];
        end

        e_full = 44'(level_reg) * 44'(log2_reg);
        mprod  = 62'(mant_reg) * 62'(roots[k_reg]);
        bprod  = 55'(base_reg) * 55'(mant_reg);
        smag   = gs_reg[15] ? (17'h10000 - {1'b0, gs_reg}) : {1'b0, gs_reg};

        // scale by 2^ei / 2^12 with saturation
        limit = gs_reg[15] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sh    = ei_reg - 12'd12;
        sh_r  = 4'(12'd12 - ei_reg);
        if (m2_reg == 42'd0)
        begin
            mag = '0;
        end
        else if (ei_reg >= 12'd12)
        begin
            if (sh >= 12'd32)
            begin
                mag = 42'(limit);
            end
            else if (m2_reg > 42'(limit >> sh[4:0]))
            begin
                mag = 42'(limit);
            end
            else
            begin
                mag = m2_reg << sh[4:0];
            end
        end
        else
        begin
            mag = m2_reg >> sh_r;
            if (mag > 42'(limit))
            begin
                mag = 42'(limit);
            end
        end

        psum = 49'(path_reg) + 49'(step_reg);
        if (psum[48:47] == 2'b01)
        begin
            path_sat = {1'b0, {47{1'b1}}};
        end
        else if (psum[48:47] == 2'b10)
        begin
            path_sat = {1'b1, {47{1'b0}}};
        end
        else
        begin
            path_sat = psum[47:0];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            mrw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = mrw_pkg::ST_PHI;
                end
            end
            mrw_pkg::ST_PHI:
            begin
                if (!issue && !p_vld_reg)
                begin
                    state_next = mrw_pkg::ST_MUL;
                end
            end
            mrw_pkg::ST_MUL:   state_next = mrw_pkg::ST_LEVEL;
            mrw_pkg::ST_LEVEL: state_next = mrw_pkg::ST_EXP;
            mrw_pkg::ST_EXP:   state_next = mrw_pkg::ST_POW;
            mrw_pkg::ST_POW:
            begin
                if (k_reg == 4'(mrw_pkg::ROOT_N - 1))
                begin
                    state_next = mrw_pkg::ST_SCALE;
                end
            end
            mrw_pkg::ST_SCALE: state_next = mrw_pkg::ST_SMUL;
            mrw_pkg::ST_SMUL:  state_next = mrw_pkg::ST_SHIFT;
            mrw_pkg::ST_SHIFT: state_next = mrw_pkg::ST_DONE;
            mrw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = mrw_pkg::ST_IDLE;
                end
            end
            default:           state_next = mrw_pkg::ST_IDLE;
        endcase
    end

    // ---------------- state and datapath registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= 24'sd65536;
            drift_reg     <= '0;
            start_reg     <= '0;
            max_reg       <= 24'd655360;
            base_reg      <= 24'd65536;
            log2_reg      <= 20'd65536;
            tcnt_reg      <= '0;
            ptr_reg       <= '0;
            level_reg     <= '0;
            path_reg      <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mrw_pkg::CFG_GAIN_A:      gain_reg  <= $signed(cfg_data);
                    mrw_pkg::CFG_DRIFT:       drift_reg <= $signed(cfg_data);
                    mrw_pkg::CFG_START_LEVEL: start_reg <= cfg_data;
                    mrw_pkg::CFG_MAX_LEVEL:   max_reg   <= cfg_data;
                    mrw_pkg::CFG_BASE_SCALE:  base_reg  <= cfg_data;
                    mrw_pkg::CFG_LOG2_LAMBDA: log2_reg  <= cfg_data[19:0];
                    default:                  ;
                endcase
            end

            // a new beat takes the output register as the old one leaves
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                mrw_pkg::ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        pos_reg   <= eta_sign;
                        gs_reg    <= gauss_sample;
                        phi_reg   <= eta_sign ? PW'($signed({1'b0, ktab[0]}))
                                              : -PW'($signed({1'b0, ktab[0]}));
                        a_reg     <= '0;
                        p_vld_reg <= 1'b0;
                        if (start_of_path)
                        begin
                            tcnt_reg  <= '0;
                            level_reg <= start_reg;
                            path_reg  <= '0;
                        end
                    end
                end
                mrw_pkg::ST_PHI:
                begin
                    if (issue)
                    begin
                        a_reg <= a_reg + TW'(1);
                    end
                    p_vld_reg <= issue;
                    p_idx_reg <= a_reg[KW-1:0];
                    if (p_vld_reg)
                    begin
                        phi_reg <= rd_sign ? phi_reg + PW'(coef) : phi_reg - PW'(coef);
                    end
                end
                mrw_pkg::ST_MUL:
                begin
                    prod_reg <= gain_reg * 48'(phi_reg);
                    ptr_reg  <= (ptr_reg == KW'(NC)) ? '0 : ptr_reg + KW'(1);
                    if (tcnt_reg != TW'(NC + 1))
                    begin
                        tcnt_reg <= tcnt_reg + TW'(1);
                    end
                end
                mrw_pkg::ST_LEVEL:
                begin
                    level_reg <= lvl_clamp;
                end
                mrw_pkg::ST_EXP:
                begin
                    ei_reg   <= e_full[43:32];
                    f_reg    <= e_full[31:16];
                    mant_reg <= 31'h4000_0000;
                    k_reg    <= '0;
                end
                mrw_pkg::ST_POW:
                begin
                    if (f_reg[4'(mrw_pkg::ROOT_N - 1) - k_reg])
                    begin
                        mant_reg <= mprod[60:30];
                    end
                    k_reg <= k_reg + 4'd1;
                end
                mrw_pkg::ST_SCALE:
                begin
                    bm_reg <= bprod[54:30];
                end
                mrw_pkg::ST_SMUL:
                begin
                    m2_reg <= 42'(bm_reg) * 42'(smag);
                end
                mrw_pkg::ST_SHIFT:
                begin
                    step_reg <= gs_reg[15] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
                end
                mrw_pkg::ST_DONE:
                begin
                    if (out_load)
                    begin
                        path_reg      <= path_sat;
                        out_path_reg  <= path_sat;
                        out_step_reg  <= step_reg;
                        out_level_reg <= level_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign path_value = out_path_reg;
    assign step_value = out_step_reg;
    assign level      = out_level_reg;

    // ---------------- assertions ----------------
    a_tcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        tcnt_reg <= TW'(NC + 1))
        else $error("time count beyond history depth");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= KW'(NC))
        else $error("history pointer out of range");

    a_read_in_phi: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> state_reg == mrw_pkg::ST_PHI)
        else $error("history read pending outside phi pass");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == mrw_pkg::ST_PHI && !p_vld_reg)
        else $error("accepted beat did not start phi pass");

endmodule
`default_nettype wire

// ----- verif/multifractal_random_walk_step_core_test.sv -----
// Self-checking testbench for the multifractal random walk step core.
`default_nettype none
module multifractal_random_walk_step_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrw_pkg::*;

    localparam int NC       = NC_DEF;
    localparam int HIST     = NC + 1;
    localparam int SETTLE   = NC + 40;      // cycles for the core to go quiet after the last beat
    localparam int WD_LIMIT = 20000;        // cycles without any beat before giving up
    // index 7 is not a register; writes to it must be dropped
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
    localparam longint PATH_HI = 64'sd140737488355327;
    localparam longint PATH_LO = -64'sd140737488355328;

    typedef struct {
        bit                 sop;
        bit                 eta;
        logic signed [15:0] gauss;
    } walk_in_t;

    typedef struct {
        logic signed [47:0] path;
        logic signed [31:0] step;
        logic        [23:0] lvl;
    } walk_out_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #2 clk = ~clk;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                start_of_path = 1'b0;
    logic                eta_sign = 1'b0;
    logic signed [15:0]  gauss_sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [47:0]  path_value;
    logic signed [31:0]  step_value;
    logic        [23:0]  level;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    multifractal_random_walk_step_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_of_path(start_of_path), .eta_sign(eta_sign), .gauss_sample(gauss_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .path_value(path_value), .step_value(step_value), .level(level),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ------------------------------------------------------------------
    // walk predictor: own copy of ROMs, history, level and path sum
    // ------------------------------------------------------------------
    longint unsigned     kcoef [HIST];      // Q1.17 1/sqrt(i+1)
    longint unsigned     root2 [16];        // Q2.30 2^(2^-(k+1))
    bit                  signs [HIST];
    int unsigned         steps_seen;
    longint              walk_level;
    longint              walk_sum;

    logic signed [23:0]  gain_q = 24'sd65536;
    logic signed [23:0]  drift_q = '0;
    logic        [23:0]  start_q = '0;
    logic        [23:0]  max_q = 24'd655360;
    logic        [23:0]  base_q = 24'd65536;
    logic        [19:0]  log2l_q = 20'd65536;

    walk_in_t  pending_beats[$];
    walk_out_t expected_walk[$];

    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  sat_steps = 0;
    int  clamped_levels = 0;
    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_sender = 0;
    bit  test_done = 0;

    function automatic longint unsigned bit_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void build_roms();
        for (int i = 0; i < HIST; i++)
            kcoef[i] = (bit_sqrt((64'd1 << 36) / longint'(i + 1)) + 1) >> 1;
        root2[0] = bit_sqrt(64'd1 << 61);
        for (int k = 1; k < 16; k++)
            root2[k] = bit_sqrt(root2[k-1] << 30);
    endfunction

    function automatic void clear_walk();
        foreach (signs[i])
            signs[i] = 1'b0;
        steps_seen = 0;
        walk_level = 0;
        walk_sum = 0;
    endfunction

    // one walk step: phi from sign history, level update, 2^exp scaling, path sum
    function automatic walk_out_t advance_walk(walk_in_t b);
        walk_out_t       r;
        longint          phi;
        longint          d;
        longint          lv;
        longint          stp;
        longint unsigned ex;
        longint unsigned ei;
        longint unsigned fr;
        longint unsigned mant;
        longint unsigned m2;
        longint unsigned lim;
        longint unsigned mag;
        longint unsigned smag;
        int unsigned     ntaps;
        bit              neg;
        neg = b.gauss[15];
        smag = neg ? longint'(-longint'(b.gauss)) : longint'(b.gauss);
        if (b.sop)
        begin
            foreach (signs[i])
                signs[i] = 1'b0;
            steps_seen = 0;
            walk_level = start_q;
            walk_sum = 0;
        end
        phi = b.eta ? longint'(kcoef[0]) : -longint'(kcoef[0]);
        if (steps_seen >= HIST)
            phi -= signs[NC] ? longint'(kcoef[NC]) : -longint'(kcoef[NC]);
        ntaps = (steps_seen < NC) ? steps_seen : NC;
        for (int i = 1; i <= ntaps; i++)
        begin
            d = longint'(kcoef[i]) - longint'(kcoef[i-1]);
            phi += signs[i-1] ? d : -d;
        end
        for (int i = HIST - 1; i > 0; i--)
            signs[i] = signs[i-1];
        signs[0] = b.eta;
        if (steps_seen < HIST)
            steps_seen++;

        lv = walk_level + (b.eta ? 65536 : -65536)
           + ((longint'(gain_q) * phi) >>> 17) - longint'(drift_q);
        if (lv < 0 || lv > longint'(max_q))
            clamped_levels++;
        if (lv < 0)
            lv = 0;
        if (lv > longint'(max_q))
            lv = max_q;
        walk_level = lv;

        ex = (longint'(walk_level) * longint'(log2l_q)) >> 16;
        ei = ex >> 16;
        fr = ex & 64'hFFFF;
        mant = 64'd1 << 30;
        for (int k = 0; k < 16; k++)
            if (fr[15-k])
                mant = (mant * root2[k]) >> 30;
        m2 = ((longint'(base_q) * mant) >> 30) * smag;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m2 == 0)
            mag = 0;
        else if (ei >= 12)
        begin
            if (ei - 12 >= 32 || m2 > (lim >> (ei - 12)))
                mag = lim;
            else
                mag = m2 << (ei - 12);
        end
        else
            mag = m2 >> (12 - ei);
        if (mag >= lim && mag != 0)
        begin
            mag = lim;
            sat_steps++;
        end
        stp = neg ? -longint'(mag) : longint'(mag);
        walk_sum += stp;
        if (walk_sum > PATH_HI)
            walk_sum = PATH_HI;
        if (walk_sum < PATH_LO)
            walk_sum = PATH_LO;
        r.path = walk_sum[47:0];
        r.step = stp[31:0];
        r.lvl = walk_level[23:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on beat %0d: %s got %0d want %0d", beats_out, field, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // driver: feeds the input channel from pending_beats, predicts on accept
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            bit      took;
            walk_in_t nb;
            took = in_valid && !in_stall;
            if (took)
            begin
                nb.sop = start_of_path;
                nb.eta = eta_sign;
                nb.gauss = gauss_sample;
                expected_walk.push_back(advance_walk(nb));
                beats_in++;
            end
            // payload holds while a beat is offered and not yet taken
            if (!in_valid || took)
            begin
                if (pending_beats.size() != 0 && !hold_sender
                    && $urandom_range(99) >= sender_idle_pct)
                begin
                    nb = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    start_of_path <= nb.sop;
                    eta_sign <= nb.eta;
                    gauss_sample <= nb.gauss;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure and field-by-field check
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            walk_out_t w;
            if (out_valid && !out_stall)
            begin
                if (expected_walk.size() == 0)
                begin
                    report_mismatch("unexpected path_value", path_value, 0);
                end
                else
                begin
                    w = expected_walk.pop_front();
                    if (path_value !== w.path)
                        report_mismatch("path_value", path_value, w.path);
                    if (step_value !== w.step)
                        report_mismatch("step_value", step_value, w.step);
                    if (level !== w.lvl)
                        report_mismatch("level", level, w.lvl);
                end
                beats_out++;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: cycles with no beat on either channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT && !test_done)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN_A:      gain_q = v;
            CFG_DRIFT:       drift_q = v;
            CFG_START_LEVEL: start_q = v;
            CFG_MAX_LEVEL:   max_q = v;
            CFG_BASE_SCALE:  base_q = v;
            CFG_LOG2_LAMBDA: log2l_q = v[19:0];
            default: ;
        endcase
    endtask

    task automatic add_beat(bit sop, bit eta, logic signed [15:0] g);
        walk_in_t b;
        b.sop = sop;
        b.eta = eta;
        b.gauss = g;
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [15:0] pick_gauss();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(3) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly whole paths long enough to fill the history, some short ones,
    // occasional restarts in the middle and paths that never saw a start
    task automatic add_paths(int n);
        int len;
        int bias;
        for (int cnt = 0; cnt < n; )
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(1, 20) : $urandom_range(66, 150);
            bias = $urandom_range(20, 80);
            for (int j = 0; j < len && cnt < n; j++, cnt++)
                add_beat((j == 0 && $urandom_range(9) != 0) || $urandom_range(99) == 0,
                         $urandom_range(99) < bias, pick_gauss());
        end
    endtask

    // wait until every queued beat is in and every result is out, then let the core settle
    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || expected_walk.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        build_roms();
        clear_walk();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 0: reset settings, no idling, directed corners first
        sender_idle_pct = 0;
        stall_pct = 0;
        add_beat(1'b0, 1'b1, 16'sh1000);        // no start seen yet
        add_beat(1'b1, 1'b1, 16'sh7FFF);
        add_beat(1'b0, 1'b1, 16'sh8000);
        add_beat(1'b0, 1'b0, 16'sh0000);
        add_beat(1'b0, 1'b0, 16'sh0001);
        add_beat(1'b0, 1'b0, 16'shFFFF);        // level driven to the floor
        add_beat(1'b0, 1'b0, 16'sh5555);
        add_beat(1'b1, 1'b0, 16'shAAAA);
        for (int j = 0; j < 10; j++)
            add_beat(1'b0, 1'b1, 16'sh7FFF);   // climb toward the ceiling
        add_paths(200);
        drain();

        // phase 1: every register at its top, drift at its most negative, saturating steps and path sum
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        write_reg(CFG_GAIN_A, 24'h7FFFFF);
        write_reg(CFG_DRIFT, 24'h800000);
        write_reg(CFG_START_LEVEL, 24'hFFFFFF);
        write_reg(CFG_MAX_LEVEL, 24'hFFFFFF);
        write_reg(CFG_BASE_SCALE, 24'hFFFFFF);
        write_reg(CFG_LOG2_LAMBDA, 24'h0FFFFF);
        sender_idle_pct = 81;
        add_paths(220);
        drain();

        // phase 2: bottom of every range, drift at its signed top
        write_reg(CFG_GAIN_A, 24'h800000);
        write_reg(CFG_DRIFT, 24'h7FFFFF);
        write_reg(CFG_START_LEVEL, 24'h000000);
        write_reg(CFG_MAX_LEVEL, 24'h000000);
        write_reg(CFG_BASE_SCALE, 24'h000000);
        write_reg(CFG_LOG2_LAMBDA, 24'h000000);
        sender_idle_pct = 0;
        stall_pct = 81;
        add_paths(220);
        drain();

        // phase 3: moderate random settings, both sides idle now and then
        write_reg(CFG_GAIN_A, 24'($urandom_range(0, 24'h3FFFF) - 24'h1FFFF));
        write_reg(CFG_DRIFT, 24'($urandom_range(0, 24'h3FFF) - 24'h1FFF));
        write_reg(CFG_START_LEVEL, 24'($urandom_range(0, 24'h50000)));
        write_reg(CFG_MAX_LEVEL, 24'($urandom_range(24'h10000, 24'h140000)));
        write_reg(CFG_BASE_SCALE, 24'($urandom_range(0, 24'h40000)));
        write_reg(CFG_LOG2_LAMBDA, 24'($urandom_range(0, 20'h20000)));
        sender_idle_pct = 22;
        stall_pct = 22;
        add_paths(220);
        drain();

        // phase 4: start level above the ceiling; sender held until results catch up
        write_reg(CFG_START_LEVEL, 24'h123456);
        write_reg(CFG_MAX_LEVEL, 24'h050000);
        write_reg(CFG_GAIN_A, 24'h010000);
        write_reg(CFG_DRIFT, 24'h000800);
        write_reg(CFG_BASE_SCALE, 24'h018000);
        write_reg(CFG_LOG2_LAMBDA, 24'h00C000);
        sender_idle_pct = 0;
        stall_pct = 81;
        add_paths(120);
        repeat (400) @(posedge clk);
        hold_sender = 1;
        while (in_valid || expected_walk.size() != 0)
            @(posedge clk);
        hold_sender = 0;
        stall_pct = 0;
        add_paths(100);
        drain();

        test_done = 1;
        $display("covered %0d input beats and %0d results over 5 register settings",
                 beats_in, beats_out);
        $display("saturated steps %0d, clamped levels %0d, errors %0d",
                 sat_steps, clamped_levels, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
